FILE: hdl/rvstep_pkg.sv
// ----------------------------------------------------------------------------
// rvstep_pkg
// Shared types and codes of the RV32I step engine: request ops and classes,
// result status codes, queue item layout, back-end sequencer states and opcodes.
// ----------------------------------------------------------------------------
package rvstep_pkg;

   localparam int unsigned SIZE_W = 13;
   localparam int unsigned ADDR_W = 12;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_EXEC  = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CLS_WRITE,
      CLS_EXEC,
      CLS_READ,
      CLS_NOP
   } cls_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_EXIT        = 3'd1,
      ST_BAD_ECALL   = 3'd2,
      ST_UNSUPPORTED = 3'd3,
      ST_NOT_RUNNING = 3'd4
   } status_type;

   typedef struct packed {
      cls_type             cls;
      logic [ADDR_W-1:0]   mem_address;
      logic [7:0]          mem_byte;
      logic [4:0]          reg_index;
   } item_type;

   typedef enum logic [2:0] {
      BS_IDLE,
      BS_READ,
      BS_DECODE,
      BS_EXEC,
      BS_LOAD
   } back_state_type;

   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   localparam logic [31:0] INS_ECALL   = 32'h0000_0073;
   localparam logic [4:0]  REG_A7      = 5'd17;
   localparam logic [31:0] EXIT_CODE   = 32'd10;
   localparam logic [31:0] JALR_MASK   = 32'hFFFF_FFFE;
   localparam logic [6:0]  F7_ZERO     = 7'h00;
   localparam logic [6:0]  F7_ALT      = 7'h20;

endpackage

FILE: hdl/rvstep_front.sv
// ----------------------------------------------------------------------------
// rvstep_front
// Accepts requests and classifies them into queue items.
// ----------------------------------------------------------------------------
module rvstep_front (
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_op,
   input  logic [rvstep_pkg::ADDR_W-1:0] req_mem_address,
   input  logic [7:0]                  req_mem_byte,
   input  logic [4:0]                  req_reg_index,
   input  logic                        q_full,
   output logic                        q_push,
   output rvstep_pkg::item_type        q_item
);
   import rvstep_pkg::*;

   cls_type cls;

   always_comb begin
      unique case (op_type'(req_op))
         OP_WRITE: cls = CLS_WRITE;
         OP_EXEC:  cls = CLS_EXEC;
         OP_READ:  cls = CLS_READ;
         default:  cls = CLS_NOP;
      endcase
   end

   assign req_ready          = !q_full;
   assign q_push             = req_valid && !q_full;
   assign q_item.cls         = cls;
   assign q_item.mem_address = req_mem_address;
   assign q_item.mem_byte    = req_mem_byte;
   assign q_item.reg_index   = req_reg_index;

endmodule

FILE: hdl/rvstep_queue.sv
// ----------------------------------------------------------------------------
// rvstep_queue
// Two-entry request queue between the front and back parts.
// ----------------------------------------------------------------------------
module rvstep_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rvstep_pkg::item_type push_item,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output rvstep_pkg::item_type head_item
);
   import rvstep_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_item = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: hdl/rvstep_back.sv
// ----------------------------------------------------------------------------
// rvstep_back
// Executes queued requests: byte memory in four banks, register file,
// fetch / decode / execute / load sequencer and the result register.
// ----------------------------------------------------------------------------
module rvstep_back #(
   parameter int unsigned MEM_BYTES = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  rvstep_pkg::item_type          q_item,
   output logic                          q_pop,
   input  logic [rvstep_pkg::SIZE_W-1:0] program_size,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_status,
   output logic [31:0]                   rsp_next_pc,
   output logic signed [31:0]            rsp_reg_value
);
   import rvstep_pkg::*;

   localparam int unsigned AW   = $clog2(MEM_BYTES);
   localparam int unsigned ROWS = MEM_BYTES / 4;
   localparam int unsigned RW   = AW - 2;

   back_state_type state_ff, state_in;
   logic [31:0] pc_ff, pc_in;
   logic        halted_ff, halted_in;
   logic [31:0] ins_ff, ins_in;

   // memory banks
   logic [7:0]    bank_mem [4][ROWS];
   logic [7:0]    rd_byte_ff [4];
   logic [1:0]    rd_a0_ff;
   logic [RW-1:0] bank_row [4];
   logic          bank_we [4];
   logic [7:0]    bank_wd [4];
   logic          mem_rd_en, mem_wr_en;
   logic [31:0]   mem_addr, mem_wdata;
   logic [3:0]    mem_mask;
   logic [31:0]   mem_word;

   // register file
   logic [31:0] rf_mem [32];
   logic [31:0] rf_valid_ff;
   logic [31:0] rf_a_ff, rf_b_ff;
   logic [4:0]  rfa_addr, rfb_addr, rf_waddr;
   logic        rf_rd_en, rf_we;
   logic [31:0] rf_wdata;

   // result register
   logic        out_free, out_load;
   logic [2:0]  out_status;
   logic [31:0] out_reg;
   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [31:0] rsp_next_pc_ff, rsp_reg_value_ff;

   // execute decode
   logic [6:0]  opc, f7;
   logic [2:0]  f3;
   logic [4:0]  rd;
   logic [31:0] a, b, imm_i, imm_s, imm_b, imm_u, imm_j;
   logic        ex_bad, ex_halt, ex_wr, ex_load, ex_store;
   logic [2:0]  ex_status;
   logic [31:0] ex_res, ex_next;
   logic [3:0]  ex_mask;
   logic [31:0] load_val;

   function automatic logic [31:0] alu(input logic [2:0] fn, input logic [31:0] x,
                                       input logic [31:0] y, input logic alt);
      logic [4:0] sh;
      logic [31:0] r;
      sh = y[4:0];
      unique case (fn)
         3'd0:    r = alt ? x - y : x + y;
         3'd1:    r = x << sh;
         3'd2:    r = {31'b0, $signed(x) < $signed(y)};
         3'd3:    r = {31'b0, x < y};
         3'd4:    r = x ^ y;
         3'd5:    r = alt ? 32'($signed(x) >>> sh) : x >> sh;
         3'd6:    r = x | y;
         default: r = x & y;
      endcase
      return r;
   endfunction

   // bank steering: byte i of the access lands in bank (addr + i) mod 4
   always_comb begin : steer
      logic [1:0]  off;
      logic [31:0] ad;
      for (int k = 0; k < 4; k++) begin
         off         = 2'(k) - mem_addr[1:0];
         ad          = mem_addr + {30'b0, off};
         bank_row[k] = ad[AW-1:2];
         bank_we[k]  = mem_wr_en && mem_mask[off];
         bank_wd[k]  = mem_wdata[8*off +: 8];
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_bank
      always_ff @(posedge clock) begin
         if (bank_we[k]) begin
            bank_mem[k][bank_row[k]] <= bank_wd[k];
         end
         if (mem_rd_en) begin
            rd_byte_ff[k] <= bank_mem[k][bank_row[k]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         rd_a0_ff <= mem_addr[1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mem_word[8*i +: 8] = rd_byte_ff[rd_a0_ff + 2'(i)];
      end
   end

   // register file: unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_waddr] <= rf_wdata;
      end
      if (rf_rd_en) begin
         rf_a_ff <= rf_valid_ff[rfa_addr] ? rf_mem[rfa_addr] : 32'b0;
         rf_b_ff <= rf_valid_ff[rfb_addr] ? rf_mem[rfb_addr] : 32'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= 32'b0;
      end else if (rf_we) begin
         rf_valid_ff[rf_waddr] <= 1'b1;
      end
   end

   // decode and execute of the held instruction
   assign opc   = ins_ff[6:0];
   assign rd    = ins_ff[11:7];
   assign f3    = ins_ff[14:12];
   assign f7    = ins_ff[31:25];
   assign a     = rf_a_ff;
   assign b     = rf_b_ff;
   assign imm_i = {{20{ins_ff[31]}}, ins_ff[31:20]};
   assign imm_s = {{20{ins_ff[31]}}, ins_ff[31:25], ins_ff[11:7]};
   assign imm_b = {{19{ins_ff[31]}}, ins_ff[31], ins_ff[7], ins_ff[30:25],
                   ins_ff[11:8], 1'b0};
   assign imm_u = {ins_ff[31:12], 12'b0};
   assign imm_j = {{11{ins_ff[31]}}, ins_ff[31], ins_ff[19:12], ins_ff[20],
                   ins_ff[30:21], 1'b0};

   always_comb begin : exec
      logic take;
      take      = 1'b0;
      ex_bad    = 1'b0;
      ex_halt   = 1'b0;
      ex_wr     = 1'b0;
      ex_load   = 1'b0;
      ex_store  = 1'b0;
      ex_status = ST_OK;
      ex_res    = 32'b0;
      ex_next   = pc_ff + 32'd4;
      ex_mask   = 4'b0000;
      unique case (opc)
         OPC_LUI: begin
            ex_res = imm_u;
            ex_wr  = 1'b1;
         end
         OPC_AUIPC: begin
            ex_res = pc_ff + imm_u;
            ex_wr  = 1'b1;
         end
         OPC_JAL: begin
            ex_res  = pc_ff + 32'd4;
            ex_wr   = 1'b1;
            ex_next = pc_ff + imm_j;
         end
         OPC_JALR: begin
            ex_bad  = (f3 != 3'd0);
            ex_res  = pc_ff + 32'd4;
            ex_wr   = 1'b1;
            ex_next = (a + imm_i) & JALR_MASK;
         end
         OPC_BRANCH: begin
            unique case (f3)
               3'd0:    take = (a == b);
               3'd1:    take = (a != b);
               3'd4:    take = $signed(a) < $signed(b);
               3'd5:    take = !($signed(a) < $signed(b));
               3'd6:    take = (a < b);
               3'd7:    take = (a >= b);
               default: ex_bad = 1'b1;
            endcase
            if (take) begin
               ex_next = pc_ff + imm_b;
            end
         end
         OPC_LOAD: begin
            ex_bad  = (f3 == 3'd3) || (f3 == 3'd6) || (f3 == 3'd7);
            ex_load = 1'b1;
         end
         OPC_STORE: begin
            ex_bad   = (f3 > 3'd2);
            ex_store = 1'b1;
            unique case (f3)
               3'd0:    ex_mask = 4'b0001;
               3'd1:    ex_mask = 4'b0011;
               default: ex_mask = 4'b1111;
            endcase
         end
         OPC_OPIMM: begin
            ex_bad = ((f3 == 3'd1) && (f7 != F7_ZERO)) ||
                     ((f3 == 3'd5) && (f7 != F7_ZERO) && (f7 != F7_ALT));
            ex_res = alu(f3, a, imm_i, (f3 == 3'd5) && (f7 == F7_ALT));
            ex_wr  = 1'b1;
         end
         OPC_OP: begin
            ex_bad = !((f7 == F7_ZERO) ||
                       ((f7 == F7_ALT) && ((f3 == 3'd0) || (f3 == 3'd5))));
            ex_res = alu(f3, a, b, f7 == F7_ALT);
            ex_wr  = 1'b1;
         end
         OPC_SYSTEM: begin
            if (ins_ff != INS_ECALL) begin
               ex_bad = 1'b1;
            end else begin
               ex_halt   = 1'b1;
               ex_status = (b == EXIT_CODE) ? ST_EXIT : ST_BAD_ECALL;
            end
         end
         default: ex_bad = 1'b1;
      endcase
      if (ex_bad) begin
         ex_halt   = 1'b1;
         ex_status = ST_UNSUPPORTED;
      end
   end

   always_comb begin
      unique case (ins_ff[14:12])
         3'd0:    load_val = {{24{mem_word[7]}}, mem_word[7:0]};
         3'd1:    load_val = {{16{mem_word[15]}}, mem_word[15:0]};
         3'd4:    load_val = {24'b0, mem_word[7:0]};
         3'd5:    load_val = {16'b0, mem_word[15:0]};
         default: load_val = mem_word;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      pc_in      = pc_ff;
      halted_in  = halted_ff;
      ins_in     = ins_ff;
      q_pop      = 1'b0;
      mem_rd_en  = 1'b0;
      mem_wr_en  = 1'b0;
      mem_addr   = pc_ff;
      mem_mask   = 4'b0000;
      mem_wdata  = b;
      rf_rd_en   = 1'b0;
      rfa_addr   = mem_word[19:15];
      rfb_addr   = (mem_word[6:0] == OPC_SYSTEM) ? REG_A7 : mem_word[24:20];
      rf_we      = 1'b0;
      rf_waddr   = rd;
      rf_wdata   = ex_res;
      out_load   = 1'b0;
      out_status = ST_OK;
      out_reg    = 32'b0;
      unique case (state_ff)
         BS_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               unique case (q_item.cls)
                  CLS_WRITE: begin
                     mem_wr_en = 1'b1;
                     mem_addr  = 32'(q_item.mem_address);
                     mem_mask  = 4'b0001;
                     mem_wdata = {24'b0, q_item.mem_byte};
                     out_load  = 1'b1;
                  end
                  CLS_READ: begin
                     rf_rd_en = 1'b1;
                     rfa_addr = q_item.reg_index;
                     state_in = BS_READ;
                  end
                  CLS_EXEC: begin
                     if (halted_ff || (pc_ff >= 32'(program_size))) begin
                        out_load   = 1'b1;
                        out_status = ST_NOT_RUNNING;
                     end else begin
                        mem_rd_en = 1'b1;
                        state_in  = BS_DECODE;
                     end
                  end
                  default: out_load = 1'b1;
               endcase
            end
         end
         BS_READ: begin
            if (out_free) begin
               out_load = 1'b1;
               out_reg  = rf_a_ff;
               state_in = BS_IDLE;
            end
         end
         BS_DECODE: begin
            rf_rd_en = 1'b1;
            ins_in   = mem_word;
            state_in = BS_EXEC;
         end
         BS_EXEC: begin
            if (ex_load && !ex_halt) begin
               mem_rd_en = 1'b1;
               mem_addr  = a + imm_i;
               state_in  = BS_LOAD;
            end else if (out_free) begin
               // commit once, when the result can be posted
               out_load   = 1'b1;
               out_status = ex_status;
               state_in   = BS_IDLE;
               if (ex_halt) begin
                  halted_in = 1'b1;
               end else begin
                  pc_in     = ex_next;
                  rf_we     = ex_wr && (rd != 5'd0);
                  mem_wr_en = ex_store;
                  mem_addr  = a + imm_s;
                  mem_mask  = ex_mask;
               end
            end
         end
         BS_LOAD: begin
            if (out_free) begin
               rf_we    = (rd != 5'd0);
               rf_wdata = load_val;
               pc_in    = pc_ff + 32'd4;
               out_load = 1'b1;
               state_in = BS_IDLE;
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         pc_ff        <= 32'b0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pc_ff     <= pc_in;
         halted_ff <= halted_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ins_ff <= ins_in;
      if (out_load) begin
         rsp_status_ff    <= out_status;
         rsp_next_pc_ff   <= pc_in;
         rsp_reg_value_ff <= out_reg;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_next_pc   = rsp_next_pc_ff;
   assign rsp_reg_value = $signed(rsp_reg_value_ff);

endmodule

FILE: hdl/rv32i_instruction_step.sv
// ----------------------------------------------------------------------------
// rv32i_instruction_step
// RV32I step engine with byte memory, register file and APB setup port.
// ----------------------------------------------------------------------------
// A request enters a two-entry queue, which absorbs up to two requests while
// the back end works; req_ready drops while the queue is full. The back end
// takes one request at a time from the queue. An executed instruction goes
// through fetch from the four byte banks, register file read and execute,
// and a load adds a second bank read. Results wait in an output register.
// MEM_BYTES must be a power of two; addresses wrap.
// The register file needs no clearing pass after reset; memory is not cleared.
// ----------------------------------------------------------------------------
module rv32i_instruction_step #(
   parameter int unsigned MEM_BYTES = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic [11:0]        req_mem_address,
   input  logic [7:0]         req_mem_byte,
   input  logic [4:0]         req_reg_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [31:0]        rsp_next_pc,
   output logic signed [31:0] rsp_reg_value,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import rvstep_pkg::*;

   logic [SIZE_W-1:0] program_size_ff;
   logic              q_full, q_push, q_pop, q_valid;
   item_type          push_item, head_item;

   // only register 0, selected by any paddr with bit 2 low; other addresses read zero
   always_ff @(posedge clock) begin
      if (reset) begin
         program_size_ff <= '0;
      end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
         program_size_ff <= pwdata[SIZE_W-1:0];
      end
   end

   assign prdata = (paddr[2] == 1'b0) ? 32'(program_size_ff) : 32'b0;
   assign pready = 1'b1;

   rvstep_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_mem_address (req_mem_address),
      .req_mem_byte    (req_mem_byte),
      .req_reg_index   (req_reg_index),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (push_item)
   );

   rvstep_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_item (head_item)
   );

   rvstep_back #(
      .MEM_BYTES (MEM_BYTES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_item        (head_item),
      .q_pop         (q_pop),
      .program_size  (program_size_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_next_pc   (rsp_next_pc),
      .rsp_reg_value (rsp_reg_value)
   );

endmodule

FILE: hdl/rvstep_checker.sv
// ----------------------------------------------------------------------------
// rvstep_checker
// Port-level checks on the result channel of the step engine.
// ----------------------------------------------------------------------------
module rvstep_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [2:0]         rsp_status,
   input logic [31:0]        rsp_next_pc,
   input logic signed [31:0] rsp_reg_value
);

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_next_pc)
                                   && $stable(rsp_reg_value))
      else $error("stalled result changed");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 3'd5) && (rsp_status != 3'd6) && (rsp_status != 3'd7))
      else $error("status code out of range");

   a_value_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != 3'd0) |-> rsp_reg_value == 32'sd0)
      else $error("register value on non-read result");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind rv32i_instruction_step rvstep_checker u_rvstep_checker (.*);
